[sv/egcd_pkg.sv]
package egcd_pkg;

    // Field widths of the words on both stream sides.
    localparam int unsigned OPND_W  = 63;
    localparam int unsigned COEF_W  = 64;
    localparam int unsigned S_DATA_W = 128;
    localparam int unsigned M_DATA_W = 192;

    // Bit count of the quotient-digit counter (one digit per operand bit).
    localparam int unsigned CNT_W = 6;
    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(OPND_W - 1);

    // One quotient digit: operands presented to the shared shift-subtract unit.
    typedef struct packed {
        logic [OPND_W-1:0] part_rem;  // partial remainder, always below the divisor
        logic              next_bit;  // next dividend bit, most significant first
        logic [OPND_W-1:0] dvsr;      // current divisor r1
        logic [COEF_W-1:0] acc_x;     // running -(q * x1), built most significant digit first
        logic [COEF_W-1:0] acc_y;     // running -(q * y1)
        logic [COEF_W-1:0] x1;
        logic [COEF_W-1:0] y1;
    } div_in_t;

    typedef struct packed {
        logic [OPND_W-1:0] part_rem;
        logic [COEF_W-1:0] acc_x;
        logic [COEF_W-1:0] acc_y;
    } div_out_t;

endpackage

[sv/egcd_div_unit.sv]
module egcd_div_unit
    import egcd_pkg::*;
(
    input  div_in_t  din,
    output div_out_t dout
);

    logic [OPND_W:0]   trial;
    logic [OPND_W:0]   diff;
    logic              take;
    logic [COEF_W-1:0] dbl_x;
    logic [COEF_W-1:0] dbl_y;

    // Restoring division digit; the same digit also scales the coefficient
    // accumulators, so x0 - q*x1 is formed without a multiplier.
    always_comb
    begin
        trial = {din.part_rem, din.next_bit};
        diff  = trial - {1'b0, din.dvsr};
        take  = (trial >= {1'b0, din.dvsr});
        dbl_x = {din.acc_x[COEF_W-2:0], 1'b0};
        dbl_y = {din.acc_y[COEF_W-2:0], 1'b0};

        dout.part_rem = take ? diff[OPND_W-1:0] : trial[OPND_W-1:0];
        dout.acc_x    = take ? (dbl_x - din.x1) : dbl_x;
        dout.acc_y    = take ? (dbl_y - din.y1) : dbl_y;
    end

endmodule

[sv/extended_gcd_bezout_core.sv]
// Operation: when operand b is zero the result is valid in the cycle after the word is taken;
// otherwise each Euclid step runs 63 quotient digits (ST_DIV) and then one update (ST_UPDATE).
// Throughput: one word at a time; s_tready is low from acceptance until the result is taken.
// Division runs on the single shift-subtract unit, which yields one quotient digit a cycle.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops m_tvalid.
module extended_gcd_bezout_core
    import egcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // operand_a [62:0], operand_b [125:63], zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // divisor [62:0], coef_a [126:63], coef_b [190:127]
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Remainder pair and coefficient pairs of the forward Euclid recurrence.
    logic [OPND_W-1:0] r0_reg, r0_next;
    logic [OPND_W-1:0] r1_reg, r1_next;
    logic [COEF_W-1:0] x0_reg, x0_next;
    logic [COEF_W-1:0] x1_reg, x1_next;
    logic [COEF_W-1:0] y0_reg, y0_next;
    logic [COEF_W-1:0] y1_reg, y1_next;

    // Division in progress: partial remainder, dividend shifter and accumulators.
    logic [OPND_W-1:0] prem_reg, prem_next;
    logic [OPND_W-1:0] dvd_reg, dvd_next;
    logic [COEF_W-1:0] accx_reg, accx_next;
    logic [COEF_W-1:0] accy_reg, accy_next;

    logic [M_DATA_W-1:0] out_reg, out_next;

    logic [OPND_W-1:0] in_a;
    logic [OPND_W-1:0] in_b;
    div_in_t           du_in;
    div_out_t          du_out;

    assign in_a = s_tdata[OPND_W-1:0];
    assign in_b = s_tdata[2*OPND_W-1:OPND_W];

    assign du_in.part_rem = prem_reg;
    assign du_in.next_bit = dvd_reg[OPND_W-1];
    assign du_in.dvsr     = r1_reg;
    assign du_in.acc_x    = accx_reg;
    assign du_in.acc_y    = accy_reg;
    assign du_in.x1       = x1_reg;
    assign du_in.y1       = y1_reg;

    egcd_div_unit u_div (
        .din  (du_in),
        .dout (du_out)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_DONE);
    assign m_tdata  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        y0_next    = y0_reg;
        y1_next    = y1_reg;
        prem_next  = prem_reg;
        dvd_next   = dvd_reg;
        accx_next  = accx_reg;
        accy_next  = accy_reg;
        out_next   = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    r0_next   = in_a;
                    r1_next   = in_b;
                    x0_next   = COEF_W'(1);
                    x1_next   = '0;
                    y0_next   = '0;
                    y1_next   = COEF_W'(1);
                    prem_next = '0;
                    dvd_next  = in_a;
                    accx_next = '0;
                    accy_next = '0;
                    cnt_next  = LAST_DIGIT;
                    if (in_b == '0)
                    begin
                        // Nothing to divide: gcd is a with coefficients one and zero.
                        out_next   = {1'b0, {COEF_W{1'b0}}, COEF_W'(1), in_a};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                prem_next = du_out.part_rem;
                accx_next = du_out.acc_x;
                accy_next = du_out.acc_y;
                dvd_next  = {dvd_reg[OPND_W-2:0], 1'b0};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                // The accumulators hold -(q * x1) and -(q * y1), modulo 2^64.
                r0_next   = r1_reg;
                r1_next   = prem_reg;
                x0_next   = x1_reg;
                x1_next   = x0_reg + accx_reg;
                y0_next   = y1_reg;
                y1_next   = y0_reg + accy_reg;
                prem_next = '0;
                dvd_next  = r1_reg;
                accx_next = '0;
                accy_next = '0;
                cnt_next  = LAST_DIGIT;
                if (prem_reg == '0)
                begin
                    out_next   = {1'b0, y1_reg, x1_reg, r1_reg};
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end

            ST_DONE:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        x0_reg   <= x0_next;
        x1_reg   <= x1_next;
        y0_reg   <= y0_next;
        y1_reg   <= y1_next;
        prem_reg <= prem_next;
        dvd_reg  <= dvd_next;
        accx_reg <= accx_next;
        accy_reg <= accy_next;
        out_reg  <= out_next;
    end

endmodule

[tb/extended_gcd_bezout_core_tb.sv]
module extended_gcd_bezout_core_tb;
    import egcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Keeps the expected gcd and Bezout coefficients for every operand pair
    // that the core has taken, oldest first, and checks each result word
    // against the oldest of them.
    class bezout_scoreboard;
        typedef struct packed {
            logic [OPND_W-1:0] divisor;
            logic [COEF_W-1:0] coef_a;
            logic [COEF_W-1:0] coef_b;
        } bezout_t;

        bezout_t     pending[$];
        int unsigned mismatches;
        int unsigned pairs_noted;
        int unsigned results_checked;

        function new();
            mismatches      = 0;
            pairs_noted     = 0;
            results_checked = 0;
        endfunction

        // Forward form of the Euclidean back-substitution. The remainders
        // and both coefficient pairs are carried at 64 bits, and the
        // coefficient updates wrap modulo 2^64 as the hardware does.
        function bezout_t bezout_of(logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
            logic [COEF_W-1:0] r0, r1, x0, x1, y0, y1;
            logic [COEF_W-1:0] q, nr, nx, ny;
            bezout_t           res;
            r0 = {1'b0, a};
            r1 = {1'b0, b};
            x0 = 64'd1;
            x1 = 64'd0;
            y0 = 64'd0;
            y1 = 64'd1;
            while (r1 != 64'd0)
            begin
                q  = r0 / r1;
                nr = r0 - q * r1;
                nx = x0 - q * x1;
                ny = y0 - q * y1;
                r0 = r1;
                r1 = nr;
                x0 = x1;
                x1 = nx;
                y0 = y1;
                y1 = ny;
            end
            res.divisor = r0[OPND_W-1:0];
            res.coef_a  = x0;
            res.coef_b  = y0;
            return res;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        function void note_operands(logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
            pending.push_back(bezout_of(a, b));
            pairs_noted++;
        endfunction

        task check_result(logic [M_DATA_W-1:0] word);
            bezout_t           want;
            logic [OPND_W-1:0] got_div;
            logic [COEF_W-1:0] got_x, got_y;
            got_div = word[OPND_W-1:0];
            got_x   = word[OPND_W +: COEF_W];
            got_y   = word[OPND_W+COEF_W +: COEF_W];
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("result word with nothing expected: gcd %0d",
                                          got_div));
            end
            else
            begin
                want = pending.pop_front();
                results_checked++;
                if (got_div !== want.divisor)
                    report_mismatch($sformatf("divisor %0d, expected %0d",
                                              got_div, want.divisor));
                if (got_x !== want.coef_a)
                    report_mismatch($sformatf("coef_a %0d, expected %0d",
                                              $signed(got_x), $signed(want.coef_a)));
                if (got_y !== want.coef_b)
                    report_mismatch($sformatf("coef_b %0d, expected %0d",
                                              $signed(got_y), $signed(want.coef_b)));
            end
        endtask
    endclass

    localparam logic [OPND_W-1:0] OPND_MAX = {OPND_W{1'b1}};
    localparam int unsigned RANDOM_PAIRS = 82;
    // Long enough that the core finishes its word and then sits on it
    // while the next operand pair waits at the input.
    localparam int unsigned HOLD_OFF_CYCLES = 8000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // operand_a [62:0], operand_b [125:63], zero pad
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // divisor [62:0], coef_a [126:63], coef_b [190:127]

    bezout_scoreboard sb;
    int unsigned      send_idle_pct;
    int unsigned      recv_stall_pct;
    int unsigned      hold_left;
    int unsigned      directed_count;

    extended_gcd_bezout_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offers one operand pair and returns at the edge at which the core takes
    // the word. Any idle cycles come first, so that valid is only lowered in
    // a step where it is not raised again.
    task automatic send_operands(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - 2*OPND_W){1'b0}}, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_operands(a, b);
    endtask

    // Random operands of several shapes: full width, shortened to a random
    // bit length so that both short and long Euclid runs occur, pairs built on
    // a common factor so that the gcd is often more than one, multiples and zeros.
    task automatic send_random_pair();
        logic [OPND_W-1:0] a, b, g;
        int unsigned       shape;
        a     = OPND_W'({$urandom, $urandom});
        b     = OPND_W'({$urandom, $urandom});
        shape = $urandom_range(9);
        case (shape)
            0, 1, 2, 3:
            begin
            end
            4, 5:
            begin
                a = a >> $urandom_range(OPND_W - 1);
                b = b >> $urandom_range(OPND_W - 1);
            end
            6, 7:
            begin
                g = OPND_W'($urandom_range(1, 1 << 20));
                a = (a >> 43) * g;
                b = (b >> 43) * g;
            end
            8:
            begin
                // One operand is a multiple of the other, or equal to it.
                b = b >> 32;
                a = b * OPND_W'($urandom_range(1, 1 << 20));
            end
            default:
            begin
                // Zero operands on either side.
                if ($urandom_range(1))
                    a = '0;
                else
                    b = '0;
            end
        endcase
        send_operands(a, b);
    endtask

    // Result side: takes a word whenever valid and ready meet, and drives
    // ready from the stall rate, or holds it low while a hold-off runs.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin
        logic [OPND_W-1:0] fib_lo, fib_hi, fib_next;
        int                i;

        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        directed_count = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Consecutive Fibonacci numbers give the longest Euclid run that fits
        // in 63 bits; the pair F91, F92 is the slowest case of all.
        fib_lo = '0;
        fib_hi = 1;
        for (i = 0; i < 91; i++)
        begin
            fib_next = fib_lo + fib_hi;
            fib_lo   = fib_hi;
            fib_hi   = fib_next;
        end

        // Directed words: zero operands on either side and both, the field
        // extremes, alternating bit patterns, the slowest pair in both
        // orders, equal operands and exact multiples.
        send_operands('0, '0);
        send_operands(OPND_MAX, '0);
        send_operands('0, OPND_MAX);
        send_operands('0, 1);
        send_operands(1, '0);
        send_operands(OPND_MAX, OPND_MAX);
        send_operands(OPND_MAX, 1);
        send_operands(1, OPND_MAX);
        send_operands(OPND_MAX, OPND_MAX - 1);
        send_operands(OPND_W'({(OPND_W/2+1){2'b01}}), OPND_W'({(OPND_W/2+1){2'b10}}));
        send_operands(fib_hi, fib_lo);
        send_operands(fib_lo, fib_hi);
        send_operands(OPND_W'(1) << (OPND_W - 1), OPND_W'(1) << (OPND_W - 2));
        send_operands(240, 46);
        send_operands(12, 18);
        send_operands(7, 7);
        send_operands(OPND_W'(6 * 1234567), 1234567);
        send_operands(1234567, OPND_W'(6 * 1234567));
        directed_count = sb.pairs_noted;

        // The core is now busy with the last directed word. Holding the
        // result side off well beyond its latency leaves the finished word
        // waiting while the next pair is offered and kept waiting at the input.
        hold_left = HOLD_OFF_CYCLES;

        for (i = 0; i < RANDOM_PAIRS; i++)
        begin
            if (i < RANDOM_PAIRS / 3)
            begin
                send_idle_pct  = 22;
                recv_stall_pct = 71;
            end
            else if (i < 2 * RANDOM_PAIRS / 3)
            begin
                send_idle_pct  = 71;
                recv_stall_pct = 22;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            send_random_pair();
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        // A word with b zero comes back in the cycle after it is taken; this
        // margin catches any stray result word after the last expected one.
        repeat (200) @(posedge clk);

        $display("Covered %0d operand pairs (%0d directed, including zero operands, the",
                 sb.pairs_noted, directed_count);
        $display("slowest Fibonacci pair and a long result hold-off); %0d results checked.",
                 sb.results_checked);
        if (sb.mismatches == 0)
            $display("extended_gcd_bezout_core verification clean");
        else
            $display("extended_gcd_bezout_core verification failed");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial
    begin
        #30_000_000;
        $display("extended_gcd_bezout_core verification failed");
        $finish;
    end

endmodule
